// ===== hdl/fud_pkg.sv =====
// shared types and constants for the form-urlencoded stream decoder
// no dependencies; used by every module of the decoder
package fud_pkg;

	// parser position within the string
	typedef enum logic [1:0] {
		MODE_EXPECT = 2'd0,
		MODE_NAME   = 2'd1,
		MODE_VALUE  = 2'd2
	} mode_t;

	// result kinds on the output tuser
	typedef enum logic [2:0] {
		KIND_NAME_BYTE  = 3'd0,
		KIND_VALUE_BYTE = 3'd1,
		KIND_NAME_END   = 3'd2,
		KIND_PARAM_END  = 3'd3,
		KIND_STRING_END = 3'd4
	} kind_t;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

	localparam int MAX_DATA = 3;

	// everything one input byte produces: data bytes first, then markers in fixed order
	typedef struct packed {
		logic [1:0]                   n_data;
		logic [MAX_DATA-1:0][7:0]     data;
		logic                         is_value;
		logic                         name_end;
		logic                         param_end;
		logic                         str_end;
	} cmd_t;

endpackage

// ===== hdl/form_urlencoded_stream_decoder_top.sv =====
// Form-urlencoded stream decoder. Takes one encoded byte per cycle on the slave
// stream while s_tready is high and returns decoded name and value bytes plus name
// end, parameter end and string end markers on the master stream, one result item
// per cycle while m_tready is high; m_tlast marks the last item caused by an input
// byte. A byte yields k items (k is 0 to 6); the command queue of QUEUE_DEPTH
// entries between the parser and the output expander absorbs such bursts, so input
// keeps flowing at one byte per cycle while the queue has room and the average
// output is at most one item per byte. The first item of a byte passes through a
// queue entry, the back end's cur_q and the output register. No reset sweep.
// depends on fud_pkg, fud_front, fud_queue, fud_back
module form_urlencoded_stream_decoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [2:0] m_tuser,   // out_kind
	output logic       m_tlast    // run_end
);
	import fud_pkg::*;

	cmd_t f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_ready;

	fud_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	fud_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	fud_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== hdl/fud_front.sv =====
// front end: accepts encoded bytes, tracks parse mode and held escape digits,
// and turns each byte into at most one command; depends on fud_pkg
module fud_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // in_byte
	input  logic          s_tlast,   // in_last
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output fud_pkg::cmd_t cmd
);
	import fud_pkg::*;

	typedef struct packed {
		logic [1:0]       n;
		logic [2:0][7:0]  db;
		logic [1:0]       cnt;
		logic [7:0]       dig;
	} acc_t;

	mode_t      mode_q;
	logic [1:0] pend_cnt_q;
	logic [7:0] pend_digit_q;

	mode_t      mode_d;
	acc_t       acc;
	logic       dval, ne, pe, se;
	logic       accept;

	function automatic logic is_hex(logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F)
			|| (c >= CH_LO_A && c <= CH_LO_F);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			v = c - CH_LO_A + HEX_ALPHA_BASE;
		end else begin
			v = c - CH_UP_A + HEX_ALPHA_BASE;
		end
		return v[3:0];
	endfunction

	function automatic acc_t push(acc_t a, logic [7:0] v);
		acc_t r;
		r = a;
		if (r.n != 2'd3) begin
			r.db[r.n] = v;
			r.n = r.n + 2'd1;
		end
		return r;
	endfunction

	// held escape bytes go out literally
	function automatic acc_t flush(acc_t a);
		acc_t r;
		r = a;
		if (r.cnt != 2'd0) begin
			r = push(r, CH_PCT);
		end
		if (r.cnt >= 2'd2) begin
			r = push(r, r.dig);
		end
		r.cnt = 2'd0;
		r.dig = 8'd0;
		return r;
	endfunction

	function automatic acc_t data_byte(acc_t a, logic [7:0] c);
		acc_t r;
		r = a;
		if (r.cnt == 2'd1 && is_hex(c)) begin
			r.dig = c;
			r.cnt = 2'd2;
		end else if (r.cnt >= 2'd2 && is_hex(c)) begin
			r = push(r, {hex_val(r.dig), hex_val(c)});
			r.cnt = 2'd0;
			r.dig = 8'd0;
		end else begin
			// a broken escape is flushed, then the byte is handled afresh
			r = flush(r);
			if (c == CH_PCT) begin
				r.cnt = 2'd1;
			end else begin
				r = push(r, (c == CH_PLUS) ? CH_SPACE : c);
			end
		end
		return r;
	endfunction

	always_comb begin
		acc.n   = 2'd0;
		acc.db  = '0;
		acc.cnt = pend_cnt_q;
		acc.dig = pend_digit_q;
		mode_d  = mode_q;
		ne = 1'b0;
		pe = 1'b0;
		se = 1'b0;

		if (mode_q != MODE_NAME && mode_q != MODE_VALUE) begin
			mode_d  = MODE_EXPECT;
			acc.cnt = 2'd0;
			acc.dig = 8'd0;
			if (s_tdata != CH_EQ && s_tdata != CH_AMP) begin
				mode_d = MODE_NAME;
			end
		end
		dval = (mode_d == MODE_VALUE);

		if (mode_d == MODE_NAME) begin
			if (s_tdata == CH_EQ) begin
				acc    = flush(acc);
				ne     = 1'b1;
				mode_d = MODE_VALUE;
			end else if (s_tdata == CH_AMP) begin
				acc    = flush(acc);
				ne     = 1'b1;
				pe     = 1'b1;
				mode_d = MODE_EXPECT;
			end else begin
				acc = data_byte(acc, s_tdata);
			end
		end else if (mode_d == MODE_VALUE) begin
			if (s_tdata == CH_AMP) begin
				acc    = flush(acc);
				pe     = 1'b1;
				mode_d = MODE_EXPECT;
			end else begin
				acc = data_byte(acc, s_tdata);
			end
		end

		if (s_tlast) begin
			if (mode_d == MODE_NAME) begin
				acc = flush(acc);
				ne  = 1'b1;
				pe  = 1'b1;
			end else if (mode_d == MODE_VALUE) begin
				acc = flush(acc);
				pe  = 1'b1;
			end
			se      = 1'b1;
			mode_d  = MODE_EXPECT;
			acc.cnt = 2'd0;
			acc.dig = 8'd0;
		end
	end

	assign cmd.n_data    = acc.n;
	assign cmd.data      = acc.db;
	assign cmd.is_value  = dval;
	assign cmd.name_end  = ne;
	assign cmd.param_end = pe;
	assign cmd.str_end   = se;

	// bytes that only change state never reach the queue
	assign s_tready  = cmd_ready;
	assign accept    = s_tvalid && s_tready;
	assign cmd_valid = s_tvalid && ((acc.n != 2'd0) || ne || pe || se);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_EXPECT;
			pend_cnt_q   <= 2'd0;
			pend_digit_q <= 8'd0;
		end else if (accept) begin
			mode_q       <= mode_d;
			pend_cnt_q   <= acc.cnt;
			pend_digit_q <= acc.dig;
		end
	end

endmodule

// ===== hdl/fud_queue.sv =====
// short command queue between front and back end, register based
// depends on fud_pkg for the command type
module fud_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fud_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output fud_pkg::cmd_t out_cmd
);
	import fud_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign in_ready  = (count_q != FULL_CNT);
	assign out_valid = (count_q != '0);
	assign out_cmd   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/fud_back.sv =====
// back end: expands one command into its result items, one per cycle while the
// output register is free, into the output register; depends on fud_pkg
module fud_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  fud_pkg::cmd_t cmd,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // out_byte
	output logic [2:0]    m_tuser,   // out_kind
	output logic          m_tlast    // run_end
);
	import fud_pkg::*;

	cmd_t       cur_q;
	logic       cur_vld_q;
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	kind_t      out_kind_q;
	logic       out_last_q;

	cmd_t       cur_nxt;
	logic [7:0] item_byte;
	kind_t      item_kind;
	logic       item_last;
	logic       out_free, adv, load_cur;

	// take the front item off the command and leave the rest
	always_comb begin
		cur_nxt   = cur_q;
		item_byte = 8'd0;
		item_kind = KIND_STRING_END;
		if (cur_q.n_data != 2'd0) begin
			item_byte    = cur_q.data[0];
			item_kind    = cur_q.is_value ? KIND_VALUE_BYTE : KIND_NAME_BYTE;
			cur_nxt.data = {8'd0, cur_q.data[MAX_DATA-1:1]};
			cur_nxt.n_data = cur_q.n_data - 2'd1;
		end else if (cur_q.name_end) begin
			item_kind        = KIND_NAME_END;
			cur_nxt.name_end = 1'b0;
		end else if (cur_q.param_end) begin
			item_kind         = KIND_PARAM_END;
			cur_nxt.param_end = 1'b0;
		end else begin
			item_kind       = KIND_STRING_END;
			cur_nxt.str_end = 1'b0;
		end
		item_last = (cur_nxt.n_data == 2'd0) && !cur_nxt.name_end
			&& !cur_nxt.param_end && !cur_nxt.str_end;
	end

	assign out_free  = !out_vld_q || m_tready;
	assign adv       = cur_vld_q && out_free;
	assign load_cur  = !cur_vld_q || (adv && item_last);
	assign cmd_ready = load_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_cur) begin
				cur_vld_q <= cmd_valid;
			end
			if (out_free) begin
				out_vld_q <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_q <= cmd;
		end else if (adv) begin
			cur_q <= cur_nxt;
		end
		if (adv) begin
			out_byte_q <= item_byte;
			out_kind_q <= item_kind;
			out_last_q <= item_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== tb/fud_checker.sv =====
// result checker for the form-urlencoded stream decoder: watches both streams,
// predicts the decoded items of every accepted input byte and compares them in order
// depends on fud_pkg
module fud_checker
	import fud_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // in_last
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // out_byte
	input  logic [2:0] m_tuser,   // out_kind
	input  logic       m_tlast,   // run_end
	output int         errors,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       run_end;
	} decoded_t;

	decoded_t decoded_q[$];

	// decoder state as the predictor sees it
	mode_t      mode;
	logic [1:0] esc_cnt;
	logic [7:0] esc_digit;

	decoded_t   burst_buf[6];
	int         burst_n;

	function automatic bit is_hex_char(logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F) ||
			(c >= CH_LO_A && c <= CH_LO_F);
	endfunction

	function automatic logic [3:0] hex_nibble(logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_ZERO && c <= CH_NINE)
			v = c - CH_ZERO;
		else if (c >= CH_LO_A && c <= CH_LO_F)
			v = c - CH_LO_A + HEX_ALPHA_BASE;
		else
			v = c - CH_UP_A + HEX_ALPHA_BASE;
		return v[3:0];
	endfunction

	function automatic void add_item(logic [7:0] b, kind_t k);
		if (burst_n < 6) begin
			burst_buf[burst_n].data = b;
			burst_buf[burst_n].kind = k;
			burst_buf[burst_n].run_end = 1'b0;
			burst_n++;
		end
	endfunction

	function automatic kind_t byte_kind();
		return (mode == MODE_VALUE) ? KIND_VALUE_BYTE : KIND_NAME_BYTE;
	endfunction

	// held escape bytes go out literally
	function automatic void flush_escape();
		kind_t k;
		k = byte_kind();
		if (esc_cnt >= 2'd1)
			add_item(CH_PCT, k);
		if (esc_cnt >= 2'd2)
			add_item(esc_digit, k);
		esc_cnt = 2'd0;
		esc_digit = 8'd0;
	endfunction

	function automatic void decode_text(logic [7:0] c);
		kind_t k;
		k = byte_kind();
		if (esc_cnt == 2'd1) begin
			if (is_hex_char(c)) begin
				esc_digit = c;
				esc_cnt = 2'd2;
				return;
			end
			flush_escape();
		end else if (esc_cnt >= 2'd2) begin
			if (is_hex_char(c)) begin
				add_item({hex_nibble(esc_digit), hex_nibble(c)}, k);
				esc_cnt = 2'd0;
				esc_digit = 8'd0;
				return;
			end
			flush_escape();
		end
		// the byte that broke an escape is handled afresh
		if (c == CH_PCT)
			esc_cnt = 2'd1;
		else
			add_item((c == CH_PLUS) ? CH_SPACE : c, k);
	endfunction

	function automatic void decode_byte(logic [7:0] c, logic last);
		burst_n = 0;
		if (mode != MODE_NAME && mode != MODE_VALUE) begin
			mode = MODE_EXPECT;
			esc_cnt = 2'd0;
			esc_digit = 8'd0;
			if (c != CH_EQ && c != CH_AMP)
				mode = MODE_NAME;
		end
		if (mode == MODE_NAME) begin
			if (c == CH_EQ) begin
				flush_escape();
				add_item(8'd0, KIND_NAME_END);
				mode = MODE_VALUE;
			end else if (c == CH_AMP) begin
				flush_escape();
				add_item(8'd0, KIND_NAME_END);
				add_item(8'd0, KIND_PARAM_END);
				mode = MODE_EXPECT;
			end else begin
				decode_text(c);
			end
		end else if (mode == MODE_VALUE) begin
			if (c == CH_AMP) begin
				flush_escape();
				add_item(8'd0, KIND_PARAM_END);
				mode = MODE_EXPECT;
			end else begin
				decode_text(c);
			end
		end
		if (last) begin
			if (mode == MODE_NAME) begin
				flush_escape();
				add_item(8'd0, KIND_NAME_END);
				add_item(8'd0, KIND_PARAM_END);
			end else if (mode == MODE_VALUE) begin
				flush_escape();
				add_item(8'd0, KIND_PARAM_END);
			end
			add_item(8'd0, KIND_STRING_END);
			mode = MODE_EXPECT;
			esc_cnt = 2'd0;
			esc_digit = 8'd0;
		end
		if (burst_n > 0)
			burst_buf[burst_n-1].run_end = 1'b1;
		for (int i = 0; i < burst_n; i++)
			decoded_q.push_back(burst_buf[i]);
	endfunction

	function automatic void note_mismatch(decoded_t want, decoded_t got);
		if (errors < 10)
			$display("mismatch at %0t: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
				$realtime, want.data, want.kind, want.run_end, got.data, got.kind, got.run_end);
		errors++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		decoded_t got;
		if (!arst_n) begin
			mode = MODE_EXPECT;
			esc_cnt = 2'd0;
			esc_digit = 8'd0;
			decoded_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got.data = m_tdata;
				got.kind = kind_t'(m_tuser);
				got.run_end = m_tlast;
				if (decoded_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected item at %0t: byte %02h kind %0d last %0b",
							$realtime, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					if (got.data !== want.data || m_tuser !== want.kind ||
						got.run_end !== want.run_end)
						note_mismatch(want, got);
				end
			end
			outstanding = decoded_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// top of the decoder testbench: clock, reset, byte stimulus with bursts and gaps,
// receiver stall patterns and the final verdict
// depends on fud_pkg, form_urlencoded_stream_decoder_top and fud_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fud_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 470;
	localparam int HOLD_CYCLES = 300;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	int errors;
	int outstanding;
	int cycle_cnt;
	int hold_req;
	int burst_left;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} char_t;

	char_t text_q[$];

	form_urlencoded_stream_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	fud_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: changing stall patterns, plus a long hold-off on request
	initial begin
		int pattern;
		int phase_left;
		int hold_seen;
		int tick;
		m_tready = 1'b0;
		phase_left = 0;
		hold_seen = 0;
		tick = 0;
		pattern = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				m_tready <= 1'b0;
				for (int i = 1; i < HOLD_CYCLES; i++)
					@(negedge clk);
			end else begin
				if (phase_left == 0) begin
					pattern = $urandom_range(0, 3);
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				case (pattern)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= (tick % 4 == 0);
					default: m_tready <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	function automatic void add_char(logic [7:0] b, logic last = 1'b0);
		char_t c;
		c.b = b;
		c.last = last;
		text_q.push_back(c);
	endfunction

	function automatic logic [7:0] hex_digit();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'(CH_ZERO + v);
		else if ($urandom_range(0, 1) == 1)
			return 8'(CH_UP_A + v - 10);
		else
			return 8'(CH_LO_A + v - 10);
	endfunction

	// name or value text: plain characters, spaces, escapes good and broken, any byte
	function automatic void add_text(int len, bit in_value);
		int r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				add_char(8'(8'h61 + $urandom_range(0, 25)));
			else if (r < 55)
				add_char(CH_PLUS);
			else if (r < 75) begin
				add_char(CH_PCT);
				add_char(hex_digit());
				add_char(hex_digit());
			end else if (r < 83) begin
				add_char(CH_PCT);
				if ($urandom_range(0, 1) == 1)
					add_char(hex_digit());
			end else if (r < 88 && in_value)
				add_char(CH_EQ);
			else
				add_char(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void add_string();
		int n_params;
		int start;
		logic [7:0] pool [6];
		char_t c;
		start = text_q.size();
		if ($urandom_range(0, 7) == 0) begin
			// noise: short runs of special characters and random bytes
			pool = '{CH_PCT, CH_EQ, CH_AMP, CH_PLUS, 8'h41, 8'h37};
			for (int i = $urandom_range(1, 8); i > 0; i--)
				add_char(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: pool[$urandom_range(0, 5)]);
		end else begin
			if ($urandom_range(0, 4) == 0)
				add_char(($urandom_range(0, 1) == 1) ? CH_AMP : CH_EQ);
			n_params = $urandom_range(1, 4);
			for (int p = 0; p < n_params; p++) begin
				add_text($urandom_range(0, 4), 1'b0);
				if ($urandom_range(0, 3) != 0) begin
					add_char(CH_EQ);
					add_text($urandom_range(0, 5), 1'b1);
				end
				if (p < n_params - 1) begin
					add_char(CH_AMP);
					if ($urandom_range(0, 9) == 0)
						add_char(CH_AMP);
				end
			end
			if ($urandom_range(0, 5) == 0)
				add_char(CH_AMP);
		end
		if (text_q.size() == start)
			add_char(8'h7a);
		c = text_q[text_q.size()-1];
		c.last = 1'b1;
		text_q[text_q.size()-1] = c;
	endfunction

	// one byte onto the input stream; bursts of random length with gaps between
	task automatic send_char(char_t c, bit allow_gap);
		int gap;
		if (allow_gap && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= c.b;
		s_tlast <= c.last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		cycle_cnt = 0;
		hold_req = 0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// skipped delimiters, escapes of both cases, '+' escape, empty value,
		// broken escapes, zero and all-ones bytes, string end in name, value and delimiter
		add_char(CH_AMP);
		add_char(CH_EQ);
		add_char(8'h61);
		add_char(CH_PCT); add_char(8'h34); add_char(8'h31);
		add_char(CH_EQ);
		add_char(CH_PCT); add_char(8'h32); add_char(8'h62);
		add_char(CH_PCT); add_char(8'h66); add_char(8'h46);
		add_char(CH_PLUS);
		add_char(CH_AMP);
		add_char(8'h63); add_char(CH_EQ); add_char(CH_AMP);
		add_char(CH_PCT); add_char(CH_PCT); add_char(8'h34); add_char(8'h31);
		add_char(CH_PCT); add_char(8'h34); add_char(CH_AMP);
		add_char(8'h00); add_char(8'hff); add_char(CH_PCT, 1'b1);
		add_char(8'h78); add_char(CH_EQ, 1'b1);
		add_char(CH_AMP, 1'b1);
		while (text_q.size() > 0)
			send_char(text_q.pop_front(), 1'b1);
		wait_drained();

		while (text_q.size() < RANDOM_ITEMS)
			add_string();
		for (int i = 0; text_q.size() > 0; i++) begin
			if (i == 150)
				hold_req++;
			if (i == 320)
				wait_drained();
			// no gaps while the receiver holds off, so the block backs up
			send_char(text_q.pop_front(), !(i >= 150 && i < 240));
		end
		wait_drained();
		repeat (16) @(negedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
